/* rtl/rfac_pkg.sv */
package rfac_pkg;

  localparam int FRAME_DIGITS = 12;
  localparam int CNT_W        = 4;
  localparam int SHIFT_W      = 4 * FRAME_DIGITS;
  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 3;
  localparam int CARD_W       = 32;
  localparam int OPEN_W       = 8;
  // entries reachable through the index field
  localparam int MAX_ENTRY    = 8;

  localparam logic [BYTE_W-1:0] START_MARK = 8'h2A;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'h23;
  localparam logic [CNT_W-1:0]  CNT_FULL   = 4'd12;
  localparam logic [CNT_W-1:0]  CNT_LONG   = 4'd13;

  typedef enum logic {
    CMD_RX    = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    V_GRANTED   = 3'd0,
    V_DENIED    = 3'd1,
    V_UNKNOWN   = 3'd2,
    V_CHECKSUM  = 3'd3,
    V_BAD_DIGIT = 3'd4,
    V_SHORT     = 3'd5,
    V_LONG      = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic               bad;
    logic [SHIFT_W-1:0] shift;
  } frame_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  index;
    logic              allowed;
    logic [OPEN_W-1:0] open_time;
  } lookup_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [CARD_W-1:0] card_number;
    logic [BYTE_W-1:0] header_byte;
    logic [IDX_W-1:0]  match_index;
    logic              reply_byte;
    logic [OPEN_W-1:0] open_seconds;
  } result_t;

  // {ok, nibble}
  function automatic logic [4:0] hex_value(logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* rtl/rfac_in_if.sv */
interface rfac_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  rx_byte;
  logic [2:0]  entry_index;
  logic [31:0] entry_card;
  logic        entry_allowed;
  logic [7:0]  entry_open_time;

  modport source (
    output valid, cmd, rx_byte, entry_index, entry_card, entry_allowed, entry_open_time,
    input  ready
  );
  modport sink (
    input  valid, cmd, rx_byte, entry_index, entry_card, entry_allowed, entry_open_time,
    output ready
  );
endinterface

/* rtl/rfac_out_if.sv */
interface rfac_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [31:0] card_number;
  logic [7:0]  header_byte;
  logic [2:0]  match_index;
  logic        reply_byte;
  logic [7:0]  open_seconds;

  modport source (
    output valid, verdict, card_number, header_byte, match_index, reply_byte, open_seconds,
    input  ready
  );
  modport sink (
    input  valid, verdict, card_number, header_byte, match_index, reply_byte, open_seconds,
    output ready
  );
endinterface

/* rtl/rfid_ascii_frame_access_check.sv */
// A frame's result is pushed into the output queue with the request holding the end mark.
// Throughput: one request per cycle; results go through a two-entry queue and
//   the input stalls only while both entries wait.
// The card table is compared in parallel and combinationally, so a lookup adds no register.
// Reset (async, active low) clears the frame state, the card table and the
//   queue at once; requests are taken from the first cycle after reset.
module rfid_ascii_frame_access_check import rfac_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfac_in_if.sink    req_i,
  rfac_out_if.source res_o
);

  // entries above the index field can never be written and never grant
  localparam int NUM_ENTRY = (TABLE_DEPTH < MAX_ENTRY) ? TABLE_DEPTH : MAX_ENTRY;

  logic              accept;
  logic              full;
  logic              frame_end;
  frame_t            frame;
  lookup_t           lookup;
  logic [CARD_W-1:0] card;
  result_t           result;
  result_t           res_data;

  assign req_i.ready = !full;
  assign accept      = req_i.valid && req_i.ready;

  rfac_frame_rx u_frame_rx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (req_i.cmd),
    .byte_i   (req_i.rx_byte),
    .frame_o  (frame),
    .end_o    (frame_end)
  );

  rfac_card_table #(
    .NUM_ENTRY (NUM_ENTRY)
  ) u_card_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (accept && (req_i.cmd == CMD_WRITE)),
    .wr_index_i   (req_i.entry_index),
    .wr_card_i    (req_i.entry_card),
    .wr_allowed_i (req_i.entry_allowed),
    .wr_open_i    (req_i.entry_open_time),
    .card_i       (card),
    .lookup_o     (lookup)
  );

  rfac_verdict u_verdict (
    .frame_i  (frame),
    .lookup_i (lookup),
    .card_o   (card),
    .result_o (result)
  );

  rfac_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_end),
    .data_i  (result),
    .full_o  (full),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_data)
  );

  assign res_o.verdict      = res_data.verdict;
  assign res_o.card_number  = res_data.card_number;
  assign res_o.header_byte  = res_data.header_byte;
  assign res_o.match_index  = res_data.match_index;
  assign res_o.reply_byte   = res_data.reply_byte;
  assign res_o.open_seconds = res_data.open_seconds;

endmodule

/* rtl/rfac_frame_rx.sv */
module rfac_frame_rx import rfac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              cmd_i,
  input  logic [BYTE_W-1:0] byte_i,
  output frame_t            frame_o,
  output logic              end_o
);

  logic   in_frame_q, in_frame_d;
  frame_t frame_q, frame_d;
  logic [4:0] hex;
  logic       rx;

  assign rx    = accept_i && (cmd_i == CMD_RX);
  assign end_o = rx && in_frame_q && (byte_i == END_MARK);
  assign hex   = hex_value(byte_i);

  always_comb begin
    in_frame_d = in_frame_q;
    frame_d    = frame_q;
    if (rx) begin
      if (!in_frame_q) begin
        if (byte_i == START_MARK) begin
          in_frame_d = 1'b1;
          frame_d    = '0;
        end
      end else if (byte_i == END_MARK) begin
        in_frame_d = 1'b0;
        frame_d    = '0;
      end else if (frame_q.count < CNT_FULL) begin
        // a bad digit shifts in as zero
        frame_d.shift = {frame_q.shift[SHIFT_W-5:0], hex[3:0]};
        frame_d.bad   = frame_q.bad | ~hex[4];
        frame_d.count = frame_q.count + 4'd1;
      end else begin
        frame_d.count = CNT_LONG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      frame_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      frame_q    <= frame_d;
    end
  end

  assign frame_o = frame_q;

endmodule

/* rtl/rfac_card_table.sv */
module rfac_card_table import rfac_pkg::*; #(
  parameter int NUM_ENTRY = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_index_i,
  input  logic [CARD_W-1:0] wr_card_i,
  input  logic              wr_allowed_i,
  input  logic [OPEN_W-1:0] wr_open_i,
  input  logic [CARD_W-1:0] card_i,
  output lookup_t           lookup_o
);

  logic [CARD_W-1:0] card_q    [NUM_ENTRY];
  logic              allowed_q [NUM_ENTRY];
  logic [OPEN_W-1:0] open_q    [NUM_ENTRY];

  logic              any;
  logic [IDX_W-1:0]  first;
  logic              sel_allowed;
  logic [OPEN_W-1:0] sel_open;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_ENTRY; j++) begin
        card_q[j]    <= '0;
        allowed_q[j] <= 1'b0;
        open_q[j]    <= '0;
      end
    end else begin
      for (int j = 0; j < NUM_ENTRY; j++) begin
        if (wr_en_i && (wr_index_i == IDX_W'(j))) begin
          card_q[j]    <= wr_card_i;
          allowed_q[j] <= wr_allowed_i;
          open_q[j]    <= wr_open_i;
        end
      end
    end
  end

  // parallel compare, lowest matching entry wins
  always_comb begin
    any         = 1'b0;
    first       = '0;
    sel_allowed = 1'b0;
    sel_open    = '0;
    for (int j = NUM_ENTRY - 1; j >= 0; j--) begin
      if (card_q[j] == card_i) begin
        any         = 1'b1;
        first       = IDX_W'(j);
        sel_allowed = allowed_q[j];
        sel_open    = open_q[j];
      end
    end
  end

  // entry 0 never counts as a hit
  assign lookup_o.hit       = any && (first != '0);
  assign lookup_o.index     = first;
  assign lookup_o.allowed   = sel_allowed;
  assign lookup_o.open_time = sel_open;

endmodule

/* rtl/rfac_verdict.sv */
module rfac_verdict import rfac_pkg::*; (
  input  frame_t            frame_i,
  input  lookup_t           lookup_i,
  output logic [CARD_W-1:0] card_o,
  output result_t           result_o
);

  logic [BYTE_W-1:0] hdr;
  logic [BYTE_W-1:0] ck;
  logic [BYTE_W-1:0] sum;

  assign hdr    = frame_i.shift[47:40];
  assign card_o = frame_i.shift[39:8];
  assign ck     = frame_i.shift[7:0];
  assign sum    = hdr ^ card_o[31:24] ^ card_o[23:16] ^ card_o[15:8] ^ card_o[7:0];

  always_comb begin
    result_o = '0;
    if (frame_i.count < CNT_FULL) begin
      result_o.verdict = V_SHORT;
    end else if (frame_i.count > CNT_FULL) begin
      result_o.verdict = V_LONG;
    end else if (frame_i.bad) begin
      result_o.verdict = V_BAD_DIGIT;
    end else begin
      result_o.card_number = card_o;
      result_o.header_byte = hdr;
      if (sum != ck) begin
        result_o.verdict = V_CHECKSUM;
      end else if (!lookup_i.hit) begin
        result_o.verdict = V_UNKNOWN;
      end else begin
        result_o.match_index = lookup_i.index;
        if (lookup_i.allowed) begin
          result_o.verdict      = V_GRANTED;
          result_o.reply_byte   = 1'b1;
          result_o.open_seconds = lookup_i.open_time;
        end else begin
          result_o.verdict = V_DENIED;
        end
      end
    end
  end

endmodule

/* rtl/rfac_out_buf.sv */
module rfac_out_buf import rfac_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/rfac_checker.sv */
module rfac_checker import rfac_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  verdict_i,
  input logic [31:0] card_number_i,
  input logic [7:0]  header_byte_i,
  input logic [2:0]  match_index_i,
  input logic        reply_byte_i,
  input logic [7:0]  open_seconds_i
);

  logic [54:0] res_payload;
  assign res_payload = {verdict_i, card_number_i, header_byte_i, match_index_i,
                        reply_byte_i, open_seconds_i};

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_payload))
    else $error("result changed while stalled");

  a_res_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(req_valid_i && req_ready_i))
    else $error("result without a preceding request");

  a_grant_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (verdict_i == V_GRANTED) |-> reply_byte_i && (match_index_i != 3'd0))
    else $error("granted result without reply or match");

  a_deny_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (verdict_i != V_GRANTED) |-> !reply_byte_i && (open_seconds_i == 8'd0))
    else $error("reply or open time on a non-granted result");

  a_format_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && ((verdict_i == V_SHORT) || (verdict_i == V_LONG) ||
                    (verdict_i == V_BAD_DIGIT))
    |-> (card_number_i == 32'd0) && (header_byte_i == 8'd0) && (match_index_i == 3'd0))
    else $error("decoded fields on a format error");

endmodule

bind rfid_ascii_frame_access_check rfac_checker u_rfac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .verdict_i      (res_o.verdict),
  .card_number_i  (res_o.card_number),
  .header_byte_i  (res_o.header_byte),
  .match_index_i  (res_o.match_index),
  .reply_byte_i   (res_o.reply_byte),
  .open_seconds_i (res_o.open_seconds)
);
